FILE: rtl/swbp_pkg.sv
// ----------------------------------------------------------------------------
// swbp_pkg
// Shared types and constants of the splat weight brush paint pipeline.
// ----------------------------------------------------------------------------
package swbp_pkg;

	localparam int MAP_SIZE_DEF    = 4096;
	localparam int LAYER_COUNT_DEF = 8;
	localparam int NUM_LAYERS      = 8;

	localparam int TEX_W   = 12;
	localparam int CRD_W   = 20;
	localparam int STR_W   = 16;
	localparam int WGT_W   = 8;
	localparam int SUM_W   = 11;
	localparam int D2_W    = 41;
	localparam int ROOT_IN_W = 58;   // d2 << 16, padded to an even width
	localparam int DIST_W  = 29;     // distance with 16 fraction bits
	localparam int QNUM_W  = 37;     // dist16 << 8
	localparam int Q_W     = 17;     // dist / radius, Q.16, clamped to one before the falloff
	localparam int NNUM_W  = 16;     // weight * 255
	localparam int CFG_W   = 20;
	localparam int IDX_W   = 3;

	localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(65536);

	// register indexes of the write port
	typedef enum logic [IDX_W-1:0] {
		REG_CENTER_X    = 3'd0,
		REG_CENTER_Z    = 3'd1,
		REG_RADIUS      = 3'd2,
		REG_STRENGTH    = 3'd3,
		REG_PAINT_LAYER = 3'd4,
		REG_LAYER_COUNT = 3'd5
	} reg_idx_t;

	typedef logic [WGT_W-1:0] wgt_t;
	typedef wgt_t [NUM_LAYERS-1:0] wvec_t;

	// brush settings; keeping them static while requests are in flight is left to the user
	typedef struct packed {
		logic [CRD_W-1:0] center_x;
		logic [CRD_W-1:0] center_z;
		logic [CRD_W-1:0] radius;
		logic [STR_W-1:0] strength;
		logic [2:0]       paint_layer;
		logic [3:0]       layer_count;
	} cfg_t;

	// flags that ride with a texel through normalization
	typedef struct packed {
		logic painted;
		logic zero_sum;
	} norm_flags_t;

endpackage

FILE: rtl/splat_weight_brush_paint_top.sv
// ----------------------------------------------------------------------------
// splat_weight_brush_paint_top
// Smoothstep brush for one texel of an eight-layer splat weight map.
// ----------------------------------------------------------------------------
// Usage:
//  Brush settings are written through wr_en / wr_index / wr_data while no
//  texel is in flight; indexes 0..5 are center_x, center_z, radius, strength,
//  paint_layer, layer_count, other indexes are ignored.
//  Texel requests enter on in_valid / in_stall with coordinates and eight
//  weights; results leave on out_valid / out_stall, one per texel, in order.
//  Throughput: one texel per cycle when no result is stalled. The pipeline
//  is made of the 29-stage square root, the 17-stage radius divider and the
//  8-stage normalizing divider, plus distance, falloff and output stages.
//  When the receiver stalls a valid result, the whole pipeline holds and
//  in_stall rises; nothing is dropped or repeated.
//  Reset clears the brush registers (painting disabled) and all valid bits.
// ----------------------------------------------------------------------------
module splat_weight_brush_paint_top
	import swbp_pkg::*;
#(
	parameter int MAP_SIZE    = MAP_SIZE_DEF,
	parameter int LAYER_COUNT = LAYER_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [TEX_W-1:0] texel_x,
	input  logic [TEX_W-1:0] texel_z,
	input  logic [WGT_W-1:0] weight_0,
	input  logic [WGT_W-1:0] weight_1,
	input  logic [WGT_W-1:0] weight_2,
	input  logic [WGT_W-1:0] weight_3,
	input  logic [WGT_W-1:0] weight_4,
	input  logic [WGT_W-1:0] weight_5,
	input  logic [WGT_W-1:0] weight_6,
	input  logic [WGT_W-1:0] weight_7,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WGT_W-1:0] new_weight_0,
	output logic [WGT_W-1:0] new_weight_1,
	output logic [WGT_W-1:0] new_weight_2,
	output logic [WGT_W-1:0] new_weight_3,
	output logic [WGT_W-1:0] new_weight_4,
	output logic [WGT_W-1:0] new_weight_5,
	output logic [WGT_W-1:0] new_weight_6,
	output logic [WGT_W-1:0] new_weight_7,
	output logic             was_painted
);

	localparam int SIDE_W = NUM_LAYERS * WGT_W + 1;
	localparam int FLG_W  = $bits(norm_flags_t);

	cfg_t        cfg_q;
	logic        en;
	wvec_t       wgt_in;

	logic        fr_vld, fr_go;
	logic [ROOT_IN_W-1:0] fr_root;
	wvec_t       fr_wgt;

	logic        rt_vld;
	logic [DIST_W-1:0] rt_dist;
	logic [SIDE_W-1:0] rt_side;

	logic        qd_vld;
	logic [0:0][Q_W-1:0] qd_q;
	logic [SIDE_W-1:0] qd_side;
	logic [0:0][QNUM_W-1:0] qd_num;

	logic        bl_vld, bl_go;
	wvec_t       bl_wgt;
	logic [SUM_W-1:0] bl_sum;

	logic [NUM_LAYERS-1:0][NNUM_W-1:0] nd_num;
	logic [SUM_W-1:0] nd_den;
	norm_flags_t nd_flg_in, nd_flg;
	logic        nd_vld;
	logic [NUM_LAYERS-1:0][WGT_W-1:0] nd_q;

	logic        out_vld_q;
	wvec_t       out_wgt_q;
	logic        out_painted_q;

	// brush registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_CENTER_X:    cfg_q.center_x    <= wr_data;
				REG_CENTER_Z:    cfg_q.center_z    <= wr_data;
				REG_RADIUS:      cfg_q.radius      <= wr_data;
				REG_STRENGTH:    cfg_q.strength    <= wr_data[STR_W-1:0];
				REG_PAINT_LAYER: cfg_q.paint_layer <= wr_data[2:0];
				REG_LAYER_COUNT: cfg_q.layer_count <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	// global advance: hold everything while a result is stalled
	assign en       = !(out_vld_q && out_stall);
	assign in_stall = !en;

	assign wgt_in = {weight_7, weight_6, weight_5, weight_4,
	                 weight_3, weight_2, weight_1, weight_0};

	swbp_front #(
		.MAP_SIZE    (MAP_SIZE),
		.LAYER_COUNT (LAYER_COUNT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (in_valid),
		.tx      (texel_x),
		.tz      (texel_z),
		.wgt_in  (wgt_in),
		.cfg     (cfg_q),
		.vld_out (fr_vld),
		.root_in (fr_root),
		.wgt_out (fr_wgt),
		.go_out  (fr_go)
	);

	swbp_sqrt #(
		.IN_W   (ROOT_IN_W),
		.SIDE_W (SIDE_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (fr_vld),
		.val_in   (fr_root),
		.side_in  ({fr_go, fr_wgt}),
		.vld_out  (rt_vld),
		.root_out (rt_dist),
		.side_out (rt_side)
	);

	// dist / radius in Q.16
	assign qd_num[0] = {rt_dist, 8'b0};

	swbp_div #(
		.LANES  (1),
		.NUM_W  (QNUM_W),
		.DEN_W  (CRD_W),
		.Q_W    (Q_W),
		.SIDE_W (SIDE_W)
	) u_qdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (rt_vld),
		.num_in   (qd_num),
		.den_in   (cfg_q.radius),
		.side_in  (rt_side),
		.vld_out  (qd_vld),
		.quo_out  (qd_q),
		.side_out (qd_side)
	);

	swbp_blend u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (qd_vld),
		.q_in    ((qd_q[0] > ONE_Q16) ? ONE_Q16 : qd_q[0]),
		.wgt_in  (qd_side[SIDE_W-2:0]),
		.go_in   (qd_side[SIDE_W-1]),
		.cfg     (cfg_q),
		.vld_out (bl_vld),
		.wgt_out (bl_wgt),
		.sum_out (bl_sum),
		.go_out  (bl_go)
	);

	// normalize: w*255/sum; unpainted texels divide by 255 and pass through
	always_comb begin
		for (int i = 0; i < NUM_LAYERS; i++) begin
			nd_num[i] = {bl_wgt[i], 8'b0} - NNUM_W'(bl_wgt[i]);
		end
		nd_den = bl_go ? bl_sum : SUM_W'(255);
		nd_flg_in.painted  = bl_go;
		nd_flg_in.zero_sum = (bl_sum == '0);
	end

	swbp_div #(
		.LANES  (NUM_LAYERS),
		.NUM_W  (NNUM_W),
		.DEN_W  (SUM_W),
		.Q_W    (WGT_W),
		.SIDE_W (FLG_W)
	) u_ndiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (bl_vld),
		.num_in   (nd_num),
		.den_in   (nd_den),
		.side_in  (nd_flg_in),
		.vld_out  (nd_vld),
		.quo_out  (nd_q),
		.side_out (nd_flg)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= nd_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_painted_q <= nd_flg.painted;
			for (int i = 0; i < NUM_LAYERS; i++) begin
				if (nd_flg.painted && nd_flg.zero_sum) begin
					out_wgt_q[i] <= (i == 0) ? 8'd255 : 8'd0;
				end else begin
					out_wgt_q[i] <= nd_q[i];
				end
			end
		end
	end

	assign out_valid    = out_vld_q;
	assign was_painted  = out_painted_q;
	assign new_weight_0 = out_wgt_q[0];
	assign new_weight_1 = out_wgt_q[1];
	assign new_weight_2 = out_wgt_q[2];
	assign new_weight_3 = out_wgt_q[3];
	assign new_weight_4 = out_wgt_q[4];
	assign new_weight_5 = out_wgt_q[5];
	assign new_weight_6 = out_wgt_q[6];
	assign new_weight_7 = out_wgt_q[7];

endmodule

FILE: rtl/swbp_front.sv
// ----------------------------------------------------------------------------
// swbp_front
// Distance terms: offsets, squares, in-brush test. Three stages.
// ----------------------------------------------------------------------------
module swbp_front
	import swbp_pkg::*;
#(
	parameter int MAP_SIZE    = MAP_SIZE_DEF,
	parameter int LAYER_COUNT = LAYER_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_in,
	input  logic [TEX_W-1:0]     tx,
	input  logic [TEX_W-1:0]     tz,
	input  wvec_t                wgt_in,
	input  cfg_t                 cfg,
	output logic                 vld_out,
	output logic [ROOT_IN_W-1:0] root_in,
	output wvec_t                wgt_out,
	output logic                 go_out
);

	logic             vld_s1, vld_s2, vld_s3;
	logic [CRD_W-1:0] dx_s1, dz_s1;
	logic             go_s1, go_s2, go_s3;
	wvec_t            wgt_s1, wgt_s2, wgt_s3;
	logic [2*CRD_W-1:0] sqx_s2, sqz_s2, rr_s2;
	logic [D2_W-1:0]  d2_s3;

	logic [CRD_W-1:0] txs, tzs, dx, dz;
	logic [3:0]       lim;
	logic             go;
	logic [D2_W-1:0]  d2;

	// offsets from the brush centre and painting enable
	always_comb begin
		txs = {tx, 8'b0};
		tzs = {tz, 8'b0};
		dx  = (txs >= cfg.center_x) ? txs - cfg.center_x : cfg.center_x - txs;
		dz  = (tzs >= cfg.center_z) ? tzs - cfg.center_z : cfg.center_z - tzs;
		lim = (32'(cfg.layer_count) < LAYER_COUNT) ? cfg.layer_count : 4'(LAYER_COUNT);
		go  = (cfg.radius != '0) && ({1'b0, cfg.paint_layer} < lim) &&
		      (32'(tx) < MAP_SIZE) && (32'(tz) < MAP_SIZE);
	end

	assign d2 = D2_W'(sqx_s2) + D2_W'(sqz_s2);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= dx;
			dz_s1  <= dz;
			go_s1  <= go;
			wgt_s1 <= wgt_in;
			sqx_s2 <= dx_s1 * dx_s1;
			sqz_s2 <= dz_s1 * dz_s1;
			rr_s2  <= cfg.radius * cfg.radius;
			go_s2  <= go_s1;
			wgt_s2 <= wgt_s1;
			d2_s3  <= d2;
			go_s3  <= go_s2 && (d2 <= {1'b0, rr_s2});
			wgt_s3 <= wgt_s2;
		end
	end

	assign vld_out = vld_s3;
	assign root_in = {1'b0, d2_s3, 16'b0};
	assign wgt_out = wgt_s3;
	assign go_out  = go_s3;

endmodule

FILE: rtl/swbp_sqrt.sv
// ----------------------------------------------------------------------------
// swbp_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module swbp_sqrt
	import swbp_pkg::*;
#(
	parameter int IN_W   = ROOT_IN_W,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_in,
	input  logic [IN_W-1:0]     val_in,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                vld_out,
	output logic [IN_W/2-1:0]   root_out,
	output logic [SIDE_W-1:0]   side_out
);

	localparam int OUT_W = IN_W / 2;
	localparam int REM_W = OUT_W + 2;

	logic              vld_s  [1:OUT_W];
	logic [REM_W-1:0]  rem_s  [1:OUT_W];
	logic [OUT_W-1:0]  res_s  [1:OUT_W];
	logic [IN_W-1:0]   bits_s [1:OUT_W];
	logic [SIDE_W-1:0] side_s [1:OUT_W];

	for (genvar i = 0; i < OUT_W; i++) begin : g_step
		logic              vld_c;
		logic [REM_W-1:0]  rem_c;
		logic [OUT_W-1:0]  res_c;
		logic [IN_W-1:0]   bits_c;
		logic [SIDE_W-1:0] side_c;
		logic [REM_W+1:0]  wide, trial;
		logic              ge;

		if (i == 0) begin : g_first
			assign vld_c  = vld_in;
			assign rem_c  = '0;
			assign res_c  = '0;
			assign bits_c = val_in;
			assign side_c = side_in;
		end else begin : g_next
			assign vld_c  = vld_s[i];
			assign rem_c  = rem_s[i];
			assign res_c  = res_s[i];
			assign bits_c = bits_s[i];
			assign side_c = side_s[i];
		end

		// bring down two bits, try to subtract 4*res+1
		assign wide  = {rem_c, bits_c[IN_W-1 -: 2]};
		assign trial = {2'b00, res_c, 2'b01};
		assign ge    = (wide >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? REM_W'(wide - trial) : REM_W'(wide);
				res_s[i+1]  <= {res_c[OUT_W-2:0], ge};
				bits_s[i+1] <= bits_c << 2;
				side_s[i+1] <= side_c;
			end
		end
	end

	assign vld_out  = vld_s[OUT_W];
	assign root_out = res_s[OUT_W];
	assign side_out = side_s[OUT_W];

endmodule

FILE: rtl/swbp_div.sv
// ----------------------------------------------------------------------------
// swbp_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. The quotient must fit in Q_W bits.
// ----------------------------------------------------------------------------
module swbp_div
	import swbp_pkg::*;
#(
	parameter int LANES  = 1,
	parameter int NUM_W  = QNUM_W,
	parameter int DEN_W  = CRD_W,
	parameter int Q_W    = swbp_pkg::Q_W,
	parameter int SIDE_W = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             vld_in,
	input  logic [LANES-1:0][NUM_W-1:0]      num_in,
	input  logic [DEN_W-1:0]                 den_in,
	input  logic [SIDE_W-1:0]                side_in,
	output logic                             vld_out,
	output logic [LANES-1:0][Q_W-1:0]        quo_out,
	output logic [SIDE_W-1:0]                side_out
);

	localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic                       vld_s  [1:Q_W];
	logic [LANES-1:0][W-1:0]    rem_s  [1:Q_W];
	logic [LANES-1:0][Q_W-1:0]  quo_s  [1:Q_W];
	logic [DEN_W-1:0]           den_s  [1:Q_W];
	logic [SIDE_W-1:0]          side_s [1:Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic                      vld_c;
		logic [LANES-1:0][W-1:0]   rem_c, rem_n;
		logic [LANES-1:0][Q_W-1:0] quo_c, quo_n;
		logic [DEN_W-1:0]          den_c;
		logic [SIDE_W-1:0]         side_c;
		logic [W-1:0]              dsh;

		if (k == 0) begin : g_first
			assign vld_c  = vld_in;
			assign quo_c  = '0;
			assign den_c  = den_in;
			assign side_c = side_in;
			for (genvar l = 0; l < LANES; l++) begin : g_ld
				assign rem_c[l] = W'(num_in[l]);
			end
		end else begin : g_next
			assign vld_c  = vld_s[k];
			assign rem_c  = rem_s[k];
			assign quo_c  = quo_s[k];
			assign den_c  = den_s[k];
			assign side_c = side_s[k];
		end

		// trial subtract of the shifted divisor in every lane
		assign dsh = W'(den_c) << (Q_W - 1 - k);
		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				quo_n[l] = quo_c[l];
				rem_n[l] = rem_c[l];
				if (rem_c[l] >= dsh) begin
					rem_n[l] = rem_c[l] - dsh;
					quo_n[l][Q_W-1-k] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= rem_n;
				quo_s[k+1]  <= quo_n;
				den_s[k+1]  <= den_c;
				side_s[k+1] <= side_c;
			end
		end
	end

	assign vld_out  = vld_s[Q_W];
	assign quo_out  = quo_s[Q_W];
	assign side_out = side_s[Q_W];

endmodule

FILE: rtl/swbp_blend.sv
// ----------------------------------------------------------------------------
// swbp_blend
// Smoothstep falloff, strength scaling, paint and clamp of the chosen layer,
// then the weight sum. Six stages.
// ----------------------------------------------------------------------------
module swbp_blend
	import swbp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  logic [Q_W-1:0]   q_in,
	input  wvec_t            wgt_in,
	input  logic             go_in,
	input  cfg_t             cfg,
	output logic             vld_out,
	output wvec_t            wgt_out,
	output logic [SUM_W-1:0] sum_out,
	output logic             go_out
);

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic               go_s1, go_s2, go_s3, go_s4, go_s5, go_s6;
	wvec_t              wgt_s1, wgt_s2, wgt_s3, wgt_s4, wgt_s5, wgt_s6;
	logic [Q_W-1:0]     t_s1, t_s2, f_s3;
	logic [2*Q_W-1:0]   tt_s2;
	logic [STR_W+Q_W-1:0] m_s4;
	logic [SUM_W-1:0]   sum_s6;

	logic [Q_W:0]       poly;
	logic [3*Q_W:0]     cube;
	logic [STR_W-1:0]   smag;
	logic [41:0]        mag, prod, acc;
	logic [13:0]        v;
	wgt_t               painted;
	wvec_t              wnew;
	logic [SUM_W-1:0]   sum;

	// falloff polynomial 3*2^16 - 2t, times t^2
	assign poly = (Q_W+1)'(3 * 65536) - {t_s2, 1'b0};
	assign cube = (3*Q_W+1)'(tt_s2) * (3*Q_W+1)'(poly);
	assign smag = cfg.strength[STR_W-1] ? STR_W'(-cfg.strength) : cfg.strength;

	// apply delta to the painted layer, clamp to 0..255
	always_comb begin
		mag  = {m_s4, 8'b0} - 42'(m_s4);
		prod = 42'({wgt_s4[cfg.paint_layer], 28'b0});
		acc  = '0;
		v    = '0;
		if (cfg.strength[STR_W-1]) begin
			if (prod >= mag) begin
				acc = prod - mag;
			end
		end else begin
			acc = prod + mag;
		end
		v = acc[41:28];
		painted = (v > 14'd255) ? 8'd255 : v[7:0];
		wnew = wgt_s4;
		if (go_s4) begin
			wnew[cfg.paint_layer] = painted;
		end
	end

	// weight sum
	always_comb begin
		sum = '0;
		for (int i = 0; i < NUM_LAYERS; i++) begin
			sum = sum + SUM_W'(wgt_s5[i]);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= ONE_Q16 - q_in;
			go_s1  <= go_in;
			wgt_s1 <= wgt_in;
			tt_s2  <= t_s1 * t_s1;
			t_s2   <= t_s1;
			go_s2  <= go_s1;
			wgt_s2 <= wgt_s1;
			f_s3   <= Q_W'(cube >> 32);
			go_s3  <= go_s2;
			wgt_s3 <= wgt_s2;
			m_s4   <= smag * f_s3;
			go_s4  <= go_s3;
			wgt_s4 <= wgt_s3;
			wgt_s5 <= wnew;
			go_s5  <= go_s4;
			sum_s6 <= sum;
			wgt_s6 <= wgt_s5;
			go_s6  <= go_s5;
		end
	end

	assign vld_out = vld_s6;
	assign wgt_out = wgt_s6;
	assign sum_out = sum_s6;
	assign go_out  = go_s6;

endmodule
